// ===== src/sqmm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sqmm_pkg
// Types and constants of the square matrix multiply unit.
// ----------------------------------------------------------------------------
package sqmm_pkg;

  localparam int DefMaxSize      = 8;
  localparam int DefElementWidth = 32;

  localparam int SIZE_W    = 4;
  localparam int VALUE_W   = 32;
  localparam int POS_W     = 3;
  localparam int RESULT_W  = 64;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [SIZE_W-1:0] SizeReset = 4'd8;

  localparam logic [0:0] REG_MATRIX_SIZE = 1'b0;

  typedef enum logic [1:0] {
    MODE_LOAD_A  = 2'd0,
    MODE_LOAD_B  = 2'd1,
    MODE_COMPUTE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_ISSUE = 2'd1,
    S_DRAIN = 2'd2
  } state_e;

endpackage
`default_nettype wire

// ===== src/square_matrix_multiply_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// square_matrix_multiply_unit
// Load words write one element of A or B; a compute word streams out the
// product A * B in row-major order, one 64-bit element per output word.
// Each product element is formed by n reads of the two element memories
// through one multiply-accumulate unit and its three pipeline stages; the
// elements of a run are worked out one after another, and a stalled output
// word holds up the next one. The unit takes no new input word until the
// run has put out its last element.
// Reset clears control and sets matrix_size to 8; both memories are left
// undefined and need no clearing pass.
// ----------------------------------------------------------------------------
module square_matrix_multiply_unit #(
  parameter int MAX_SIZE      = sqmm_pkg::DefMaxSize,
  parameter int ELEMENT_WIDTH = sqmm_pkg::DefElementWidth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,

  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sqmm_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [sqmm_pkg::PDATA_W-1:0]  pwdata,
  output logic      [sqmm_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,

  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    mode_i,
  input  wire logic [sqmm_pkg::POS_W-1:0]    row_i,
  input  wire logic [sqmm_pkg::POS_W-1:0]    col_i,
  input  wire logic [sqmm_pkg::VALUE_W-1:0]  value_i,

  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [sqmm_pkg::POS_W-1:0]    out_row_o,
  output logic      [sqmm_pkg::POS_W-1:0]    out_col_o,
  output logic      [sqmm_pkg::RESULT_W-1:0] product_element_o,
  output logic                               last_o
);
  import sqmm_pkg::*;

  localparam int EW        = (ELEMENT_WIDTH > VALUE_W) ? VALUE_W : ELEMENT_WIDTH;
  localparam int DEPTH     = MAX_SIZE * MAX_SIZE;
  localparam int IDX_W     = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int ADDR_W    = (MAX_SIZE > 1) ? $clog2(DEPTH) : 1;
  localparam int WIDE_W    = ADDR_W + 4;
  localparam int MUL_W     = 2 * EW;
  localparam int N_W       = 8;

  // configuration
  logic [SIZE_W-1:0] size_q;
  logic              cfg_wr;

  // control
  state_e            state_q, state_d;
  logic              accept;
  logic              load_a, load_b, start;
  logic              issue, out_load, last_elem;
  logic [IDX_W-1:0]  i_q, j_q, k_q;
  logic [IDX_W-1:0]  n_m1_q, n_m1;
  logic [N_W-1:0]    size_ext, n_clamped, n_less;

  // memories and addresses
  logic [EW-1:0]     a_mem [DEPTH];
  logic [EW-1:0]     b_mem [DEPTH];
  logic [WIDE_W-1:0] load_addr_w;
  logic [ADDR_W-1:0] load_addr, a_addr, b_addr;
  logic              load_in_grid;

  // multiply-accumulate pipeline
  logic [EW-1:0]       a_rd_q, b_rd_q;
  logic                rd_v_q, rd_first_q, rd_last_q;
  logic [MUL_W-1:0]    mul_q;
  logic                mul_v_q, mul_first_q, mul_last_q;
  logic [RESULT_W-1:0] acc_q;
  logic                acc_done_q;

  // output register
  logic                out_valid_q;
  logic [IDX_W+POS_W-1:0] i_ext, j_ext;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[PADDR_W-1] == REG_MATRIX_SIZE);
  assign prdata = (paddr[PADDR_W-1] == REG_MATRIX_SIZE) ? PDATA_W'(size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeReset;
    end else if (cfg_wr) begin
      size_q <= pwdata[SIZE_W-1:0];
    end
  end

  assign size_ext  = N_W'(size_q);
  assign n_clamped = (size_q == '0) ? N_W'(1) :
                     ((size_ext > N_W'(MAX_SIZE)) ? N_W'(MAX_SIZE) : size_ext);
  assign n_less    = n_clamped - N_W'(1);
  assign n_m1      = n_less[IDX_W-1:0];

  // --------------------------------------------------------------------------
  // input decode
  // --------------------------------------------------------------------------
  assign accept = in_valid_i && !in_stall_o;

  assign load_addr_w  = WIDE_W'(row_i) * WIDE_W'(MAX_SIZE) + WIDE_W'(col_i);
  assign load_addr    = load_addr_w[ADDR_W-1:0];
  assign load_in_grid = (WIDE_W'(row_i) < WIDE_W'(MAX_SIZE))
                        && (WIDE_W'(col_i) < WIDE_W'(MAX_SIZE));

  always_comb begin
    load_a = 1'b0;
    load_b = 1'b0;
    start  = 1'b0;
    case (mode_i)
      MODE_LOAD_A:  load_a = accept && load_in_grid;
      MODE_LOAD_B:  load_b = accept && load_in_grid;
      MODE_COMPUTE: start  = accept;
      default:      ;
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  assign last_elem = (i_q == n_m1_q) && (j_q == n_m1_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (k_q == n_m1_q) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (out_load) begin
          state_d = last_elem ? S_IDLE : S_ISSUE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    issue      = (state_q == S_ISSUE);
    out_load   = (state_q == S_DRAIN) && acc_done_q && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      n_m1_q  <= '0;
    end else begin
      state_q <= state_d;
      if (start) begin
        i_q    <= '0;
        j_q    <= '0;
        k_q    <= '0;
        n_m1_q <= n_m1;
      end else if (issue) begin
        k_q <= (k_q == n_m1_q) ? '0 : k_q + IDX_W'(1);
      end else if (out_load) begin
        if (j_q == n_m1_q) begin
          j_q <= '0;
          i_q <= i_q + IDX_W'(1);
        end else begin
          j_q <= j_q + IDX_W'(1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // element memories
  // --------------------------------------------------------------------------
  assign a_addr = ADDR_W'(i_q) * ADDR_W'(MAX_SIZE) + ADDR_W'(k_q);
  assign b_addr = ADDR_W'(k_q) * ADDR_W'(MAX_SIZE) + ADDR_W'(j_q);

  always_ff @(posedge clk_i) begin
    if (load_a) begin
      a_mem[load_addr] <= value_i[EW-1:0];
    end
    if (issue) begin
      a_rd_q <= a_mem[a_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_b) begin
      b_mem[load_addr] <= value_i[EW-1:0];
    end
    if (issue) begin
      b_rd_q <= b_mem[b_addr];
    end
  end

  // --------------------------------------------------------------------------
  // multiply-accumulate
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q      <= 1'b0;
      rd_first_q  <= 1'b0;
      rd_last_q   <= 1'b0;
      mul_v_q     <= 1'b0;
      mul_first_q <= 1'b0;
      mul_last_q  <= 1'b0;
      acc_done_q  <= 1'b0;
    end else begin
      rd_v_q      <= issue;
      rd_first_q  <= (k_q == '0);
      rd_last_q   <= (k_q == n_m1_q);
      mul_v_q     <= rd_v_q;
      mul_first_q <= rd_first_q;
      mul_last_q  <= rd_last_q;
      if (mul_v_q && mul_last_q) begin
        acc_done_q <= 1'b1;
      end else if (out_load) begin
        acc_done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      mul_q <= MUL_W'(a_rd_q) * MUL_W'(b_rd_q);
    end
    if (mul_v_q) begin
      acc_q <= (mul_first_q ? '0 : acc_q) + RESULT_W'(mul_q);
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  assign i_ext = (IDX_W+POS_W)'(i_q);
  assign j_ext = (IDX_W+POS_W)'(j_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_row_o         <= i_ext[POS_W-1:0];
      out_col_o         <= j_ext[POS_W-1:0];
      product_element_o <= acc_q;
      last_o            <= last_elem;
    end
  end

  assign out_valid_o = out_valid_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> (!rd_v_q && !mul_v_q && !acc_done_q))
    else $error("input taken while multiply-accumulate pipeline busy");

  a_done_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_done_q |-> (state_q == S_DRAIN))
    else $error("finished element outside drain state");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last_elem) |=> (state_q == S_IDLE))
    else $error("run did not end after its last element");

endmodule
`default_nettype wire

// ===== sim/square_matrix_multiply_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_matrix_multiply_unit_checker
// Watches the configuration port and both word channels of the matrix
// multiply unit. Mirrors the two element stores and the size register, works
// out every product word a compute word must produce, and compares the words
// that leave the unit field by field, in order, against that list.
// ----------------------------------------------------------------------------
module square_matrix_multiply_unit_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,

  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [sqmm_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [sqmm_pkg::PDATA_W-1:0]    pwdata,
  input  wire logic                            pready,

  input  wire logic                            in_valid_i,
  input  wire logic                            in_stall_i,
  input  wire logic [1:0]                      mode_i,
  input  wire logic [sqmm_pkg::POS_W-1:0]      row_i,
  input  wire logic [sqmm_pkg::POS_W-1:0]      col_i,
  input  wire logic [sqmm_pkg::VALUE_W-1:0]    value_i,

  input  wire logic                            out_valid_i,
  input  wire logic                            out_stall_i,
  input  wire logic [sqmm_pkg::POS_W-1:0]      out_row_i,
  input  wire logic [sqmm_pkg::POS_W-1:0]      out_col_i,
  input  wire logic [sqmm_pkg::RESULT_W-1:0]   product_element_i,
  input  wire logic                            last_i,

  output int unsigned                          errors_o,
  output int unsigned                          pending_o
);
  import sqmm_pkg::*;

  localparam int GridCells = DefMaxSize * DefMaxSize;
  localparam logic [PADDR_W-1:0] SizeAddr = {REG_MATRIX_SIZE, 2'b00};

  typedef struct packed {
    logic [POS_W-1:0]    row;
    logic [POS_W-1:0]    col;
    logic [RESULT_W-1:0] elem;
    logic                last;
  } product_t;

  logic [VALUE_W-1:0] a_elem [GridCells];
  logic [VALUE_W-1:0] b_elem [GridCells];
  logic [SIZE_W-1:0]  size_reg;
  product_t           product_q [$];
  int unsigned        mismatches;

  function automatic int unsigned used_size(logic [SIZE_W-1:0] code);
    if (code == 0) return 1;
    if (code > DefMaxSize) return DefMaxSize;
    return 32'(code);
  endfunction

  task automatic predict_word(logic [1:0] mode, logic [POS_W-1:0] row,
                              logic [POS_W-1:0] col, logic [VALUE_W-1:0] value);
    int unsigned n;
    int          idx;
    logic [RESULT_W-1:0] acc;
    logic [RESULT_W-1:0] ea;
    logic [RESULT_W-1:0] eb;
    product_t    p;
    idx = int'(row) * DefMaxSize + int'(col);
    case (mode)
      MODE_LOAD_A: begin
        if (row < DefMaxSize && col < DefMaxSize) a_elem[idx] = value;
      end
      MODE_LOAD_B: begin
        if (row < DefMaxSize && col < DefMaxSize) b_elem[idx] = value;
      end
      MODE_COMPUTE: begin
        n = used_size(size_reg);
        for (int i = 0; i < n; i++) begin
          for (int j = 0; j < n; j++) begin
            acc = '0;
            for (int k = 0; k < n; k++) begin
              ea = RESULT_W'(a_elem[i * DefMaxSize + k]);
              eb = RESULT_W'(b_elem[k * DefMaxSize + j]);
              acc = acc + ea * eb;
            end
            p.row  = POS_W'(i);
            p.col  = POS_W'(j);
            p.elem = acc;
            p.last = (i == n - 1) && (j == n - 1);
            product_q.push_back(p);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_word();
    product_t exp_w;
    if (product_q.size() == 0) begin
      $error("unexpected product word: row %0d col %0d value %h",
             out_row_i, out_col_i, product_element_i);
      mismatches++;
      return;
    end
    exp_w = product_q.pop_front();
    if (out_row_i !== exp_w.row) begin
      $error("out_row mismatch: expected %0d, actual %0d", exp_w.row, out_row_i);
      mismatches++;
    end
    if (out_col_i !== exp_w.col) begin
      $error("out_col mismatch: expected %0d, actual %0d", exp_w.col, out_col_i);
      mismatches++;
    end
    if (product_element_i !== exp_w.elem) begin
      $error("product_element mismatch: expected %h, actual %h",
             exp_w.elem, product_element_i);
      mismatches++;
    end
    if (last_i !== exp_w.last) begin
      $error("last mismatch: expected %0d, actual %0d", exp_w.last, last_i);
      mismatches++;
    end
  endtask

  initial begin
    mismatches = 0;
    errors_o   = 0;
    pending_o  = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_reg = SizeReset;
      product_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_word();
      if (in_valid_i && !in_stall_i) predict_word(mode_i, row_i, col_i, value_i);
      if (psel && penable && pwrite && pready && paddr == SizeAddr)
        size_reg = pwdata[SIZE_W-1:0];
    end
    errors_o  <= mismatches;
    pending_o <= product_q.size();
  end

endmodule

// ===== sim/square_matrix_multiply_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_matrix_multiply_unit_test
// Drives the matrix multiply unit with element loads and compute words over
// a range of matrix sizes, with bursty input and a varying output stall, and
// reports the verdict of the checker that runs beside the unit.
// ----------------------------------------------------------------------------
module square_matrix_multiply_unit_test;
  import sqmm_pkg::*;

  localparam int          GridCells   = DefMaxSize * DefMaxSize;
  localparam int          RandomItems = 100;
  localparam int          DrainCycles = 16;
  localparam logic [1:0]  ModeUnused  = 2'd3;
  localparam logic [PADDR_W-1:0] SizeAddr = {REG_MATRIX_SIZE, 2'b00};
  localparam logic [VALUE_W-1:0] AllOnes  = '1;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [PADDR_W-1:0]    paddr       = '0;
  logic [PDATA_W-1:0]    pwdata      = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [1:0]            mode_i      = '0;
  logic [POS_W-1:0]      row_i       = '0;
  logic [POS_W-1:0]      col_i       = '0;
  logic [VALUE_W-1:0]    value_i     = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [POS_W-1:0]      out_row_o;
  logic [POS_W-1:0]      out_col_o;
  logic [RESULT_W-1:0]   product_element_o;
  logic                  last_o;

  int unsigned           error_count;
  int unsigned           pending_count;

  bit                    a_done [GridCells];
  bit                    b_done [GridCells];
  logic [SIZE_W-1:0]     size_code = SizeReset;
  int unsigned           words_sent = 0;
  int unsigned           burst_left = 0;
  int unsigned           stall_style = 0;
  int unsigned           style_left = 0;

  always #10 clk_i = ~clk_i;

  square_matrix_multiply_unit DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .mode_i            (mode_i),
    .row_i             (row_i),
    .col_i             (col_i),
    .value_i           (value_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_row_o         (out_row_o),
    .out_col_o         (out_col_o),
    .product_element_o (product_element_o),
    .last_o            (last_o)
  );

  square_matrix_multiply_unit_checker checker_inst (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .mode_i            (mode_i),
    .row_i             (row_i),
    .col_i             (col_i),
    .value_i           (value_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_row_i         (out_row_o),
    .out_col_i         (out_col_o),
    .product_element_i (product_element_o),
    .last_i            (last_o),
    .errors_o          (error_count),
    .pending_o         (pending_count)
  );

  // output stall: free-flowing, coin-flip and heavy stretches
  always @(negedge clk_i) begin
    if (style_left == 0) begin
      stall_style = $urandom_range(0, 2);
      style_left  = $urandom_range(16, 96);
    end else begin
      style_left = style_left - 1;
    end
    case (stall_style)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  function automatic int unsigned used_size(logic [SIZE_W-1:0] code);
    if (code == 0) return 1;
    if (code > DefMaxSize) return DefMaxSize;
    return 32'(code);
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return AllOnes;
      2:       return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(logic [1:0] mode, logic [POS_W-1:0] row,
                           logic [POS_W-1:0] col, logic [VALUE_W-1:0] value);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    row_i      <= row;
    col_i      <= col;
    value_i    <= value;
    do @(posedge clk_i); while (in_stall_o);
    if (mode != ModeUnused) words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  task automatic load(logic [1:0] mode, int unsigned row, int unsigned col,
                      logic [VALUE_W-1:0] value);
    send_word(mode, POS_W'(row), POS_W'(col), value);
    if (mode == MODE_LOAD_A) a_done[row * DefMaxSize + col] = 1'b1;
    else b_done[row * DefMaxSize + col] = 1'b1;
  endtask

  task automatic compute();
    send_word(MODE_COMPUTE, POS_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, 7)),
              $urandom);
  endtask

  task automatic send_unused();
    send_word(ModeUnused, POS_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, 7)),
              $urandom);
  endtask

  // hold input until every product word is out and the unit has settled
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_size(logic [PDATA_W-1:0] data);
    wait_idle();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SizeAddr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    size_code = data[SIZE_W-1:0];
  endtask

  task automatic fill(int unsigned n);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        if (!a_done[i * DefMaxSize + j]) load(MODE_LOAD_A, i, j, rand_value());
        if (!b_done[i * DefMaxSize + j]) load(MODE_LOAD_B, i, j, rand_value());
      end
  endtask

  initial begin
    int unsigned n;
    int unsigned extra;
    int unsigned pick;
    logic [SIZE_W-1:0] code;
    logic [PDATA_W-1:0] data;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // single element, largest values
    write_size(1);
    load(MODE_LOAD_A, 0, 0, AllOnes);
    load(MODE_LOAD_B, 0, 0, AllOnes);
    compute();
    send_unused();
    // size zero behaves as one
    write_size(0);
    load(MODE_LOAD_A, 0, 0, '0);
    compute();
    // two by two of all ones: sum wraps
    write_size(2);
    load(MODE_LOAD_A, 0, 0, AllOnes);
    load(MODE_LOAD_A, 0, 1, AllOnes);
    load(MODE_LOAD_A, 1, 0, AllOnes);
    load(MODE_LOAD_A, 1, 1, AllOnes);
    load(MODE_LOAD_B, 0, 1, AllOnes);
    load(MODE_LOAD_B, 1, 0, AllOnes);
    load(MODE_LOAD_B, 1, 1, AllOnes);
    compute();
    // loads outside the active size are stored but unused
    load(MODE_LOAD_A, 7, 7, rand_value());
    load(MODE_LOAD_B, 7, 7, rand_value());
    compute();

    words_sent = 0;
    while (words_sent < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) code = SIZE_W'($urandom_range(1, 3));
      else if (pick < 75) code = SIZE_W'($urandom_range(4, 5));
      else if (pick < 87) code = SIZE_W'($urandom_range(6, 7));
      else if (pick < 93) code = SIZE_W'(DefMaxSize);
      else if (pick < 97) code = '0;
      else code = SIZE_W'($urandom_range(DefMaxSize + 1, 15));
      if (code != size_code || $urandom_range(0, 3) == 0) begin
        data = $urandom_range(0, 1) ? $urandom : '0;
        data[SIZE_W-1:0] = code;
        write_size(data);
      end
      n = used_size(size_code);
      fill(n);
      extra = $urandom_range(0, n * n);
      repeat (extra) begin
        if ($urandom_range(0, 4) == 0)
          load($urandom_range(0, 1) ? MODE_LOAD_A : MODE_LOAD_B,
               $urandom_range(0, 7), $urandom_range(0, 7), rand_value());
        else
          load($urandom_range(0, 1) ? MODE_LOAD_A : MODE_LOAD_B,
               $urandom_range(0, n - 1), $urandom_range(0, n - 1), rand_value());
      end
      if ($urandom_range(0, 4) == 0)
        send_unused();
      if ($urandom_range(0, 5) == 0) wait_idle();
      compute();
      if ($urandom_range(0, 3) == 0) compute();
    end

    // full grid, once through an oversized code and once at the reset value
    write_size(15);
    fill(DefMaxSize);
    compute();
    write_size(DefMaxSize);
    compute();

    wait_idle();
    if (error_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sqmm_pkg.sv
src/square_matrix_multiply_unit.sv
sim/square_matrix_multiply_unit_checker.sv
sim/square_matrix_multiply_unit_test.sv
